// ===== design/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared constants, command/status bundles and controller states.
// ----------------------------------------------------------------------------
package pee_pkg;

   localparam int PEE_STACK_DEPTH = 64;
   localparam int PEE_WORD_W      = 32;
   localparam int PEE_DIV_STEPS   = 32;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;
   localparam logic [1:0] STATUS_DIVZERO   = 2'd3;

   localparam logic [PEE_WORD_W-1:0] EMPTY_WORD = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLOSE,
      S_POPB,
      S_POPA,
      S_EXEC,
      S_DIV,
      S_POPF,
      S_EMIT
   } pee_state_type;

   typedef struct packed {
      logic capture;
      logic close;
      logic pop;
      logic latch_b;
      logic exec;
      logic push_div;
      logic load_rsp;
   } pee_cmd_type;

   typedef struct packed {
      logic req_digit;
      logic req_last;
      logic is_op;
      logic is_div;
      logic last;
      logic halted;
      logic b_zero;
      logic div_busy;
      logic rsp_busy;
   } pee_status_type;

endpackage

// ===== design/pee_req_if.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator request channel
// Valid/ready channel carrying one expression character per transaction.
// ----------------------------------------------------------------------------
interface pee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== design/pee_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator response channel
// Valid/ready channel carrying the evaluated value and its status.
// ----------------------------------------------------------------------------
interface pee_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [1:0]         status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== design/pee_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pee_divider.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Iterative restoring divider, one quotient bit per cycle, signed truncation.
// ----------------------------------------------------------------------------
module pee_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);
   import pee_pkg::*;

   localparam int STEP_W = $clog2(PEE_DIV_STEPS);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [31:0]       quo_ff, quo_in;
   logic [31:0]       rem_ff, rem_in;
   logic [31:0]       mag_b_ff, mag_b_in;
   logic              neg_ff, neg_in;
   logic [32:0]       rem_sh;
   logic [32:0]       diff;

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      rem_sh   = {rem_ff, quo_ff[31]};
      diff     = rem_sh - {1'b0, mag_b_ff};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         quo_in   = dividend[31] ? (32'd0 - dividend) : dividend;
         mag_b_in = divisor[31] ? (32'd0 - divisor) : divisor;
         rem_in   = '0;
         neg_in   = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(PEE_DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff  <= step_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule

// ===== design/pee_datapath.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Digit accumulator, operand stack, ALU, divider, error tracking and
// response register, driven by controller commands.
// ----------------------------------------------------------------------------
module pee_datapath #(
   parameter int STACK_DEPTH = pee_pkg::PEE_STACK_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pee_pkg::pee_cmd_type   cmd,
   output pee_pkg::pee_status_type stat,
   input  logic [7:0]             req_char_code,
   input  logic                   req_last_char,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_value,
   output logic [1:0]             rsp_status
);
   import pee_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [7:0]    char_ff;
   logic          last_ff;
   logic [31:0]   acc_ff, acc_in;
   logic          in_num_ff, in_num_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    err_ff, err_in;
   logic          halted_ff, halted_in;
   logic [31:0]   b_ff;
   logic          pop_empty_ff, pop_empty_in;
   logic          valid_ff, valid_in;
   logic [31:0]   value_ff;
   logic [1:0]    status_ff;

   logic          req_digit;
   logic          is_op;
   logic          is_div;
   logic          full;
   logic          empty;
   logic [CW-1:0] cnt_dec;
   logic [31:0]   rd_data;
   logic [31:0]   pop_val;
   logic [31:0]   alu;
   logic          push_en;
   logic [31:0]   push_data;
   logic          wr_en;
   logic          rd_en;
   logic          note_en;
   logic [1:0]    note_code;
   logic          div_start;
   logic          div_busy;
   logic [31:0]   quotient;

   assign req_digit = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
   assign is_op     = (char_ff == CHAR_PLUS) || (char_ff == CHAR_MINUS) ||
                      (char_ff == CHAR_STAR) || (char_ff == CHAR_SLASH);
   assign is_div    = (char_ff == CHAR_SLASH);
   assign full      = (cnt_ff == CW'(STACK_DEPTH));
   assign empty     = (cnt_ff == '0);
   assign cnt_dec   = cnt_ff - CW'(1);
   assign pop_val   = pop_empty_ff ? EMPTY_WORD : rd_data;

   always_comb begin
      case (char_ff)
         CHAR_PLUS:  alu = pop_val + b_ff;
         CHAR_MINUS: alu = pop_val - b_ff;
         CHAR_STAR:  alu = pop_val * b_ff;
         default:    alu = pop_val * b_ff;
      endcase
   end

   always_comb begin
      push_en   = 1'b0;
      push_data = acc_ff;
      note_en   = 1'b0;
      note_code = STATUS_OK;
      div_start = 1'b0;
      halted_in = halted_ff;
      acc_in    = acc_ff;
      in_num_in = in_num_ff;
      pop_empty_in = pop_empty_ff;

      if (cmd.capture && req_digit) begin
         acc_in    = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} +
                     {28'd0, req_char_code[3:0]};
         in_num_in = 1'b1;
      end
      if (cmd.close && in_num_ff) begin
         push_en   = 1'b1;
         push_data = acc_ff;
         acc_in    = '0;
         in_num_in = 1'b0;
      end
      if (cmd.exec) begin
         if (!is_div) begin
            push_en   = 1'b1;
            push_data = alu;
         end else if (b_ff == '0) begin
            note_en   = 1'b1;
            note_code = STATUS_DIVZERO;
            halted_in = 1'b1;
         end else begin
            div_start = 1'b1;
         end
      end
      if (cmd.push_div) begin
         push_en   = 1'b1;
         push_data = quotient;
      end
      if (push_en && full) begin
         note_en   = 1'b1;
         note_code = STATUS_OVERFLOW;
      end
      if (cmd.pop) begin
         pop_empty_in = empty;
         if (empty) begin
            note_en   = 1'b1;
            note_code = STATUS_UNDERFLOW;
         end
      end

      wr_en = push_en && !full;
      rd_en = cmd.pop && !empty;

      cnt_in = cnt_ff;
      if (wr_en) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (rd_en) begin
         cnt_in = cnt_dec;
      end

      err_in = err_ff;
      if (note_en && (err_ff == STATUS_OK)) begin
         err_in = note_code;
      end

      valid_in = valid_ff && !rsp_ready;
      if (cmd.load_rsp) begin
         valid_in  = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         in_num_in = 1'b0;
         err_in    = STATUS_OK;
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         in_num_ff <= 1'b0;
         cnt_ff    <= '0;
         err_ff    <= STATUS_OK;
         halted_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         in_num_ff <= in_num_in;
         cnt_ff    <= cnt_in;
         err_ff    <= err_in;
         halted_ff <= halted_in;
         valid_ff  <= valid_in;
      end
      if (cmd.capture) begin
         char_ff <= req_char_code;
         last_ff <= req_last_char;
      end
      if (cmd.latch_b) begin
         b_ff <= pop_val;
      end
      pop_empty_ff <= pop_empty_in;
      if (cmd.load_rsp) begin
         value_ff  <= pop_val;
         status_ff <= err_ff;
      end
   end

   pee_ram #(
      .WIDTH (PEE_WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (push_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_dec[AW-1:0]),
      .rd_data (rd_data)
   );

   pee_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pop_val),
      .divisor  (b_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      stat.req_digit = req_digit;
      stat.req_last  = req_last_char;
      stat.is_op     = is_op;
      stat.is_div    = is_div;
      stat.last      = last_ff;
      stat.halted    = halted_ff;
      stat.b_zero    = (b_ff == '0);
      stat.div_busy  = div_busy;
      stat.rsp_busy  = valid_ff && !rsp_ready;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

endmodule

// ===== design/pee_controller.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences character capture, stack pushes and pops, operator execution,
// division wait and result emission.
// ----------------------------------------------------------------------------
module pee_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pee_pkg::pee_status_type stat,
   output pee_pkg::pee_cmd_type    cmd
);
   import pee_pkg::*;

   pee_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!(stat.req_digit && !stat.req_last)) begin
                  state_in = S_CLOSE;
               end
            end
         end
         S_CLOSE: begin
            cmd.close = 1'b1;
            if (stat.is_op && !stat.halted) begin
               state_in = S_POPB;
            end else if (stat.last) begin
               state_in = S_POPF;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_POPB: begin
            cmd.pop  = 1'b1;
            state_in = S_POPA;
         end
         S_POPA: begin
            cmd.latch_b = 1'b1;
            cmd.pop     = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.is_div && !stat.b_zero) begin
               state_in = S_DIV;
            end else if (stat.last) begin
               state_in = S_POPF;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (!stat.div_busy) begin
               cmd.push_div = 1'b1;
               state_in     = stat.last ? S_POPF : S_IDLE;
            end
         end
         S_POPF: begin
            cmd.pop  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/postfix_expression_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a postfix expression streamed one ASCII character per request
// transaction; the final character carries last_char. Digit runs form
// 32-bit operands on a stack of STACK_DEPTH words, + - * / combine the top
// two with signed wrapping arithmetic and truncating division. After the
// final character one response transaction returns the popped top and a
// status (ok, underflow, overflow, divide by zero; first error wins), and
// the unit clears for the next expression.
// A digit is accumulated on capture; any other character or a final digit
// then closes the pending number, and an operator pops two stack words
// through the registered read port of the stack RAM, then executes; a
// division then waits for the bit-per-cycle divider. After a division by
// zero later operators are not executed. The final character pops the top
// and loads the response register; rsp_valid rises in the cycle after that.
// Reset empties the stack and clears all errors; no clearing pass runs.
// A stalled response holds in its register while the next expression
// streams in; only the next final character waits for it to be taken.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit #(
   parameter int STACK_DEPTH = pee_pkg::PEE_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   pee_req_if.sink    req_bus,
   pee_rsp_if.source  rsp_bus
);
   import pee_pkg::*;

   pee_cmd_type    cmd;
   pee_status_type stat;
   logic [31:0]    rsp_value;

   pee_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pee_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_char_code (req_bus.char_code),
      .req_last_char (req_bus.last_char),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_bus.status)
   );

   assign rsp_bus.value = $signed(rsp_value);

endmodule
